// ----- hw/rtl/flh_pkg.sv -----
`timescale 1ns / 1ps
package flh_pkg;

  localparam logic [63:0] K1 = 64'h87c37b916942566d;
  localparam logic [63:0] K2 = 64'hacf5ad43274593b9;
  localparam logic [63:0] K3 = 64'ha951abd7ed558e35;
  localparam logic [63:0] K4 = 64'hc673b96e1a85ed39;
  localparam logic [63:0] K5 = 64'hc3a5c85c97cb3199;
  localparam logic [63:0] K6 = 64'hb492b66f5e98f273;
  localparam logic [63:0] K7 = 64'h9ae16a3b2d853d67;
  localparam logic [63:0] K8 = 64'hc9d64a2ae57b2457;
  localparam logic [63:0] K9 = 64'h6789ab5de12356bd;
  localparam logic [63:0] KA = 64'h7ab98cd21ef34ac5;
  localparam logic [63:0] KB = 64'h939b961b3a3ef3df;
  localparam logic [63:0] KC = 64'h7294d1ab85f24c45;
  localparam logic [63:0] KD = 64'h96f6a7a1d23a526d;
  localparam logic [63:0] KF = 64'h8a5fd6b32d5a3a17;

  localparam logic [1:0] CFG_SEED_ONE   = 2'd0;
  localparam logic [1:0] CFG_SEED_TWO   = 2'd1;
  localparam logic [1:0] CFG_SEED_THREE = 2'd2;
  localparam logic [1:0] CFG_SEED_FOUR  = 2'd3;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } flh_in_t;

  typedef struct packed {
    logic [63:0] digest_first;
    logic [63:0] digest_second;
  } flh_out_t;

  // product requests to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } flh_mul_req_t;

  function automatic logic [63:0] rot(input logic [63:0] x, input logic [5:0] r);
    logic [127:0] d;
    d = {x, x} << r;
    return d[127:64];
  endfunction

endpackage

// ----- hw/rtl/flh_mul.sv -----
`timescale 1ns / 1ps
module flh_mul import flh_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  flh_mul_req_t req,
  output logic         done,
  output logic [63:0]  prod
);

  // 64x64 low product from three 32x32 partials, one per cycle
  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [31:0] opa, opb;
  logic [63:0] p32;
  logic [63:0] pp;

  always_comb begin
    opa = (step_r == 3'd2) ? a_r[63:32] : a_r[31:0];
    opb = (step_r == 3'd1) ? b_r[63:32] : b_r[31:0];
    p32 = opa * opb;
    pp = 64'd0;
    case (step_r)
      3'd0: pp = p32;
      3'd1, 3'd2: pp = {p32[31:0], 32'd0};
      default: pp = 64'd0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 3'd0;
      acc_nxt  = 64'd0;
    end else if (busy_r) begin
      acc_nxt  = acc_r + pp;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd2) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    acc_r <= acc_nxt;
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
  end

  assign done = busy_r && !busy_nxt;
  assign prod = acc_nxt;

endmodule

// ----- hw/rtl/four_lane_hash_64bit_lanes.sv -----
`timescale 1ns / 1ps
// one shared 64-bit multiplier; each product is issued, then built from three 32x32 partials
// non-last item: buffered, except a group-completing item: 8 products, then a mix
// last item: up to 20 products (round, 8-byte tail, pre-mix, finalizer)
// result waits in the output register; input stalls while busy or while out_stall holds it
// synchronous active-low reset: seeds 1..4, buffer empty, no result pending
module four_lane_hash_64bit_lanes import flh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  flh_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output flh_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RMUL  = 7'b0000010,
    S_RMIX  = 7'b0000100,
    S_TAIL  = 7'b0001000,
    S_TMUL  = 7'b0010000,
    S_PMUL  = 7'b0100000,
    S_FMUL  = 7'b1000000
  } state_t;

  state_t      st_r, st_nxt;
  logic [63:0] seed_r [4];
  logic [63:0] h_r [4];
  logic [63:0] buf_r [4];
  logic [63:0] t_r [8];
  logic [1:0]  held_r;
  logic        seen_r;
  logic [2:0]  mi_r;
  logic        mwait_r;
  logic        tailp_r;
  logic [5:0]  rem_r;
  logic [1:0]  kind_r;
  flh_out_t    out_r;
  logic        ovld_r;

  flh_mul_req_t mreq;
  logic         mdone;
  logic [63:0]  mprod;

  flh_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .done(mdone), .prod(mprod));

  logic [63:0] ma, mb;
  logic [2:0]  mcnt;

  // operand selection for product index mi_r
  always_comb begin
    ma = 64'd0;
    mb = 64'd0;
    mcnt = 3'd7;
    case (st_r)
      S_RMUL: begin
        case (mi_r)
          3'd0: begin ma = buf_r[0] ^ h_r[0]; mb = K1; end
          3'd1: begin ma = rot(h_r[3] ^ buf_r[1], 6'd32); mb = K5; end
          3'd2: begin ma = buf_r[1] ^ h_r[1]; mb = K2; end
          3'd3: begin ma = rot(h_r[0] ^ buf_r[2], 6'd32); mb = K6; end
          3'd4: begin ma = buf_r[2] ^ h_r[2]; mb = K3; end
          3'd5: begin ma = rot(h_r[1] ^ buf_r[3], 6'd32); mb = K7; end
          3'd6: begin ma = buf_r[3] ^ h_r[3]; mb = K4; end
          default: begin ma = rot(h_r[2] ^ buf_r[0], 6'd32); mb = K8; end
        endcase
      end
      S_TMUL: begin
        if (kind_r != 2'd1) begin
          mcnt = 3'd3;
          case (mi_r)
            3'd0: begin ma = buf_r[0] ^ h_r[0]; mb = K1; end
            3'd1: begin ma = rot(buf_r[0], 6'd32) ^ h_r[1]; mb = K2; end
            3'd2: begin ma = rot(buf_r[0], 6'd16) ^ h_r[2]; mb = K3; end
            default: begin ma = rot(buf_r[0], 6'd48) ^ h_r[3]; mb = K4; end
          endcase
        end else begin
          case (mi_r)
            3'd0: begin ma = buf_r[0] ^ h_r[0]; mb = K1; end
            3'd1: begin ma = rot(h_r[3] ^ buf_r[0], 6'd32); mb = K5; end
            3'd2: begin ma = buf_r[1] ^ h_r[1]; mb = K2; end
            3'd3: begin ma = rot(h_r[0] ^ buf_r[1], 6'd32); mb = K6; end
            3'd4: begin ma = buf_r[0] ^ h_r[2]; mb = K3; end
            3'd5: begin ma = rot(h_r[1] ^ buf_r[1], 6'd32); mb = K7; end
            3'd6: begin ma = buf_r[1] ^ h_r[3]; mb = K4; end
            default: begin ma = rot(h_r[2] ^ buf_r[0], 6'd32); mb = K8; end
          endcase
        end
      end
      S_PMUL: begin
        mcnt = 3'd3;
        case (mi_r)
          3'd0: begin ma = rot(h_r[0], 6'd24) ^ rot(h_r[1], 6'd23); mb = K9; end
          3'd1: begin ma = rot(h_r[1], 6'd24) ^ rot(h_r[2], 6'd23); mb = KA; end
          3'd2: begin ma = rot(h_r[2], 6'd24) ^ rot(h_r[3], 6'd23); mb = KB; end
          default: begin ma = rot(h_r[3], 6'd24) ^ rot(h_r[0], 6'd23); mb = KC; end
        endcase
      end
      S_FMUL: begin
        mcnt = 3'd3;
        case (mi_r)
          3'd0: begin ma = rot(h_r[0], 6'd23) ^ rot(h_r[2], 6'd24); mb = KD; end
          3'd1: begin ma = rot(h_r[0], 6'd24) ^ rot(h_r[2], 6'd23); mb = KF; end
          3'd2: begin ma = rot(h_r[1], 6'd23) ^ rot(h_r[3], 6'd24); mb = KD; end
          default: begin ma = rot(h_r[1], 6'd24) ^ rot(h_r[3], 6'd23); mb = KF; end
        endcase
      end
      default: ;
    endcase
  end

  logic mul_phase;
  assign mul_phase = (st_r == S_RMUL) || (st_r == S_TMUL) || (st_r == S_PMUL) ||
                     (st_r == S_FMUL);
  assign mreq.start = mul_phase && !mwait_r;
  assign mreq.a = ma;
  assign mreq.b = mb;

  logic        acc;
  logic        fresh;
  logic [3:0]  n_sat;
  logic [63:0] w_m, mask;
  logic [5:0]  i_rem;
  logic        mdone_last;
  logic        add32;

  assign acc   = in_valid && !in_stall;
  assign fresh = !seen_r && held_r == 2'd0;
  assign n_sat = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
  assign mask  = (n_sat == 4'd8) ? {64{1'b1}} : ((64'd1 << {n_sat[2:0], 3'b000}) - 64'd1);
  assign w_m   = in_data.data_word & mask;
  assign i_rem = {1'b0, held_r, 3'b000} + {2'b00, n_sat};
  assign mdone_last = mdone && (mi_r == mcnt);
  // the request completes a 32-byte group
  assign add32 = (held_r == 2'd3) && (!in_data.last || n_sat == 4'd8);

  assign in_stall  = (st_r != S_IDLE) || (ovld_r && out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = ovld_r;
  assign out_data  = out_r;

  logic [63:0] h0, h1, h2, h3;
  always_comb begin
    h0 = fresh ? seed_r[0] : h_r[0];
    h1 = fresh ? seed_r[1] : h_r[1];
    h2 = fresh ? seed_r[2] : h_r[2];
    h3 = fresh ? seed_r[3] : h_r[3];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (!in_data.last) st_nxt = (held_r == 2'd3) ? S_RMUL : S_IDLE;
          else if (!seen_r && n_sat == 4'd0) st_nxt = S_TMUL;
          else if (i_rem == 6'd32) st_nxt = S_RMUL;
          else st_nxt = S_TAIL;
        end
      end
      S_RMUL: if (mdone_last) st_nxt = S_RMIX;
      S_RMIX: st_nxt = tailp_r ? S_TAIL : ((kind_r == 2'd3) ? S_PMUL : S_IDLE);
      S_TAIL: st_nxt = (rem_r > 6'd16) ? S_RMUL : S_TMUL;
      S_TMUL: if (mdone_last) st_nxt = (kind_r == 2'd2) ? S_FMUL : S_PMUL;
      S_PMUL: if (mdone_last) st_nxt = S_FMUL;
      S_FMUL: if (mdone_last) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic [63:0] m1, m2, m3, m4;
  assign m1 = t_r[0] + t_r[1];
  assign m2 = t_r[2] + t_r[3];
  assign m3 = t_r[4] + t_r[5];
  assign m4 = t_r[6] + t_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      seed_r[0] <= 64'd1;
      seed_r[1] <= 64'd2;
      seed_r[2] <= 64'd3;
      seed_r[3] <= 64'd4;
      held_r  <= 2'd0;
      seen_r  <= 1'b0;
      mi_r    <= 3'd0;
      mwait_r <= 1'b0;
      tailp_r <= 1'b0;
      kind_r  <= 2'd0;
      ovld_r  <= 1'b0;
      for (int k = 0; k < 4; k++) buf_r[k] <= 64'd0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEED_ONE:   seed_r[0] <= cfg_data;
          CFG_SEED_TWO:   seed_r[1] <= cfg_data;
          CFG_SEED_THREE: seed_r[2] <= cfg_data;
          CFG_SEED_FOUR:  seed_r[3] <= cfg_data;
          default: ;
        endcase
      end
      if (ovld_r && !out_stall) ovld_r <= 1'b0;

      if (mreq.start) mwait_r <= 1'b1;
      if (mdone) begin
        mwait_r <= 1'b0;
        t_r[mi_r] <= mprod;
        mi_r <= (mi_r == mcnt) ? 3'd0 : mi_r + 3'd1;
      end

      case (st_r)
        S_IDLE: begin
          if (acc) begin
            h_r[0] <= add32 ? h0 + 64'd32 : h0;
            h_r[1] <= h1; h_r[2] <= h2; h_r[3] <= h3;
            mi_r <= 3'd0;
            if (!in_data.last) begin
              buf_r[held_r] <= in_data.data_word;
              held_r <= held_r + 2'd1;
              seen_r <= 1'b1;
              tailp_r <= 1'b0;
            end else if (!seen_r && n_sat == 4'd0) begin
              buf_r[0] <= K1;
              kind_r <= 2'd2;
            end else if (i_rem == 6'd32) begin
              buf_r[3] <= w_m;
              tailp_r <= 1'b1;
              rem_r <= 6'd0;
            end else begin
              buf_r[held_r] <= w_m;
              rem_r <= i_rem;
            end
          end
        end
        S_RMIX: begin
          h_r[0] <= (m1 ^ rot(m3, 6'd31)) + m2;
          h_r[1] <= (m2 ^ rot(m4, 6'd31)) + m3;
          h_r[2] <= (m3 ^ rot(m1, 6'd32)) + m4;
          h_r[3] <= (m4 ^ rot(m2, 6'd32)) + m1;
          held_r <= 2'd0;
          tailp_r <= 1'b0;
          for (int k = 0; k < 4; k++) buf_r[k] <= 64'd0;
        end
        S_TAIL: begin
          h_r[0] <= h_r[0] - {58'd0, rem_r};
          h_r[1] <= h_r[1] + {58'd0, rem_r};
          kind_r <= (rem_r <= 6'd8) ? 2'd0 : ((rem_r <= 6'd16) ? 2'd1 : 2'd3);
          if (rem_r > 6'd16) begin
            tailp_r <= 1'b0;
          end
        end
        S_TMUL: begin
          if (mdone_last) begin
            if (kind_r == 2'd1) begin
              h_r[0] <= m1; h_r[1] <= m2; h_r[2] <= m3; h_r[3] <= mprod + t_r[6];
            end else begin
              h_r[0] <= t_r[0]; h_r[1] <= t_r[1]; h_r[2] <= t_r[2]; h_r[3] <= mprod;
            end
          end
        end
        S_PMUL: begin
          if (mdone_last) begin
            h_r[0] <= t_r[0]; h_r[1] <= t_r[1]; h_r[2] <= t_r[2]; h_r[3] <= mprod;
          end
        end
        S_FMUL: begin
          if (mdone_last) begin
            out_r.digest_first  <= t_r[0] ^ t_r[1];
            out_r.digest_second <= t_r[2] ^ mprod;
            ovld_r <= 1'b1;
            for (int k = 0; k < 4; k++) buf_r[k] <= 64'd0;
            held_r <= 2'd0;
            seen_r <= 1'b0;
            kind_r <= 2'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
